@@ rtl/sib_pkg.sv @@
package sib_pkg;

	// item kinds
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// request word
	typedef struct packed {
		logic               kind;
		logic [31:0]        sample_time;
		logic [31:0]        command_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] current_x;
		logic signed [31:0] current_y;
	} req_t;

	// response word
	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               from_history;
	} rsp_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_QSTART,
		ST_QPREV,
		ST_QCMP,
		ST_RDA,
		ST_RDB,
		ST_DIV,
		ST_MULX,
		ST_MULY,
		ST_FINY,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic add;
		logic rd_walk;
		logic save_prev;
		logic rd_s0;
		logic rd_s1;
		logic div_load;
		logic div_step;
		logic cap_a;
		logic cap_b;
		logic mul_x;
		logic mul_y;
		logic fin_x;
		logic fin_y;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_valid;
		logic req_kind;
		logic count_lt2;
		logic match;
		logic walk_last;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/snapshot_interpolation_buffer.sv @@
// channel  signals                    word
// request  req_valid, req_stall, req  kind, sample_time, command_id, pos, current
// response rsp_valid, rsp_stall, rsp  out_x, out_y, from_history
//
// one word at a time: a query is paced by the one-read-port entry walk and the
// bit-serial divider, then by one shared multiplier for x and y.
// reset clears the ring bookkeeping and control only; entries are not cleared.
// a finished response waits in the output register while the next word is taken.
module snapshot_interpolation_buffer #(
	parameter int SNAPSHOT_DEPTH = 16,
	parameter int FRACTION_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sib_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sib_pkg::rsp_t rsp
);

	sib_pkg::cmd_t cmd;
	sib_pkg::sts_t sts;

	// sequencer
	sib_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd),
		.stall  (req_stall)
	);

	// storage and arithmetic
	sib_dp #(
		.SNAPSHOT_DEPTH (SNAPSHOT_DEPTH),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_valid (req_valid && !req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// an add never loads a response
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.kind == sib_pkg::KIND_ADD |=> !cmd.out_load)
		else $error("response loaded for an add word");

	// a waiting response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !rsp_valid || !rsp_stall)
		else $error("response overwritten while stalled");

	// a loaded response shows up next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid)
		else $error("loaded response not presented");

	// divider never loaded and stepped together
	a_div_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !cmd.div_load)
		else $error("divider load and step clash");

endmodule

@@ rtl/sib_ctrl.sv @@
module sib_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  sib_pkg::sts_t sts,
	output sib_pkg::cmd_t cmd,
	output logic          stall
);

	sib_pkg::state_t state_q;
	sib_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sib_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sib_pkg::ST_IDLE: begin
				if (sts.req_valid) begin
					state_nxt = (sts.req_kind == sib_pkg::KIND_ADD) ?
						sib_pkg::ST_ADD : sib_pkg::ST_QSTART;
				end
			end
			sib_pkg::ST_ADD:    state_nxt = sib_pkg::ST_IDLE;
			sib_pkg::ST_QSTART: begin
				state_nxt = sts.count_lt2 ? sib_pkg::ST_RESULT : sib_pkg::ST_QPREV;
			end
			sib_pkg::ST_QPREV:  state_nxt = sib_pkg::ST_QCMP;
			sib_pkg::ST_QCMP: begin
				if (sts.match) begin
					state_nxt = sib_pkg::ST_RDA;
				end else if (sts.walk_last) begin
					state_nxt = sib_pkg::ST_RESULT;
				end
			end
			sib_pkg::ST_RDA:    state_nxt = sib_pkg::ST_RDB;
			sib_pkg::ST_RDB:    state_nxt = sib_pkg::ST_DIV;
			sib_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = sib_pkg::ST_MULX;
				end
			end
			sib_pkg::ST_MULX:   state_nxt = sib_pkg::ST_MULY;
			sib_pkg::ST_MULY:   state_nxt = sib_pkg::ST_FINY;
			sib_pkg::ST_FINY:   state_nxt = sib_pkg::ST_RESULT;
			sib_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					state_nxt = sib_pkg::ST_IDLE;
				end
			end
			default:            state_nxt = sib_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			sib_pkg::ST_IDLE:   cmd.load_in = sts.req_valid;
			sib_pkg::ST_ADD:    cmd.add = 1'b1;
			sib_pkg::ST_QSTART: cmd.rd_walk = !sts.count_lt2;
			sib_pkg::ST_QPREV: begin
				cmd.save_prev = 1'b1;
				cmd.rd_walk   = 1'b1;
			end
			sib_pkg::ST_QCMP: begin
				if (sts.match) begin
					cmd.div_load = 1'b1;
					cmd.rd_s0    = 1'b1;
				end else if (!sts.walk_last) begin
					cmd.save_prev = 1'b1;
					cmd.rd_walk   = 1'b1;
				end
			end
			sib_pkg::ST_RDA: begin
				cmd.cap_a    = 1'b1;
				cmd.rd_s1    = 1'b1;
				cmd.div_step = 1'b1;
			end
			sib_pkg::ST_RDB: begin
				cmd.cap_b    = 1'b1;
				cmd.div_step = 1'b1;
			end
			sib_pkg::ST_DIV:    cmd.div_step = 1'b1;
			sib_pkg::ST_MULX:   cmd.mul_x = 1'b1;
			sib_pkg::ST_MULY: begin
				cmd.fin_x = 1'b1;
				cmd.mul_y = 1'b1;
			end
			sib_pkg::ST_FINY:   cmd.fin_y = 1'b1;
			sib_pkg::ST_RESULT: cmd.out_load = sts.out_free;
			default:            cmd = '0;
		endcase
	end

	assign stall = (state_q != sib_pkg::ST_IDLE);

endmodule

@@ rtl/sib_dp.sv @@
module sib_dp #(
	parameter int SNAPSHOT_DEPTH = 16,
	parameter int FRACTION_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sib_pkg::cmd_t cmd,
	output sib_pkg::sts_t sts,
	input  logic          req_valid,
	input  sib_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sib_pkg::rsp_t rsp
);

	localparam int IDX_W  = $clog2(SNAPSHOT_DEPTH);
	localparam int CNT_W  = $clog2(SNAPSHOT_DEPTH + 1);
	localparam int DCNT_W = $clog2(FRACTION_BITS);
	localparam int PROD_W = FRACTION_BITS + 34;

	// snapshot memories
	logic [31:0] mem_time [SNAPSHOT_DEPTH];
	logic [31:0] mem_x    [SNAPSHOT_DEPTH];
	logic [31:0] mem_y    [SNAPSHOT_DEPTH];

	sib_pkg::req_t      req_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [31:0]        newest_q;
	logic [IDX_W-1:0]   walk_slot_q;
	logic [CNT_W-1:0]   walk_off_q;
	logic [IDX_W-1:0]   sl_q;
	logic [IDX_W-1:0]   sl_prev_q;
	logic [31:0]        t_prev_q;
	logic [31:0]        rd_time_q;
	logic [31:0]        rd_x_q;
	logic [31:0]        rd_y_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [31:0]        a_x_q;
	logic [31:0]        a_y_q;
	logic signed [32:0] diff_x_q;
	logic signed [32:0] diff_y_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [31:0]        res_x_q;
	logic [31:0]        res_y_q;
	logic               hist_q;
	logic               rsp_valid_q;
	sib_pkg::rsp_t      rsp_q;

	logic [CNT_W:0]     slot_sum;
	logic [IDX_W-1:0]   wr_slot;
	logic               dup;
	logic [IDX_W-1:0]   rd_addr;
	logic [32:0]        div_sh;
	logic               div_ge;
	logic signed [32:0] mul_a;
	logic signed [FRACTION_BITS:0] frac_s;

	function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] s);
		slot_next = (s == IDX_W'(SNAPSHOT_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	// write slot: oldest plus count, wrapped once (also gives oldest when full)
	always_comb begin
		slot_sum = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
		if (slot_sum >= (CNT_W + 1)'(SNAPSHOT_DEPTH)) begin
			slot_sum = slot_sum - (CNT_W + 1)'(SNAPSHOT_DEPTH);
		end
		wr_slot = slot_sum[IDX_W-1:0];
	end

	assign dup = (count_q != '0) && (req_q.command_id == newest_q);

	// read address select
	always_comb begin
		if (cmd.rd_s0) begin
			rd_addr = sl_prev_q;
		end else if (cmd.rd_s1) begin
			rd_addr = sl_q;
		end else begin
			rd_addr = walk_slot_q;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.add && !dup) begin
			mem_time[wr_slot] <= req_q.sample_time;
			mem_x[wr_slot]    <= req_q.pos_x;
			mem_y[wr_slot]    <= req_q.pos_y;
		end
		rd_time_q <= mem_time[rd_addr];
		rd_x_q    <= mem_x[rd_addr];
		rd_y_q    <= mem_y[rd_addr];
	end

	// ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			oldest_q <= '0;
			newest_q <= '0;
		end else if (cmd.add && !dup) begin
			newest_q <= req_q.command_id;
			if (count_q < CNT_W'(SNAPSHOT_DEPTH)) begin
				count_q <= count_q + 1'b1;
			end else begin
				oldest_q <= slot_next(oldest_q);
			end
		end
	end

	// request word and walk pointers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q       <= req;
			walk_slot_q <= oldest_q;
			walk_off_q  <= '0;
		end
		if (cmd.rd_walk) begin
			walk_slot_q <= slot_next(walk_slot_q);
			walk_off_q  <= walk_off_q + 1'b1;
			sl_q        <= walk_slot_q;
			sl_prev_q   <= sl_q;
		end
		if (cmd.save_prev) begin
			t_prev_q <= rd_time_q;
		end
	end

	// history flag, set when a bracketing pair is found
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= 1'b0;
		end else if (cmd.load_in) begin
			hist_q <= 1'b0;
		end else if (cmd.div_load) begin
			hist_q <= 1'b1;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign div_sh = {rem_q, 1'b0};
	assign div_ge = (div_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_cnt_q <= '0;
			quo_q     <= '0;
			if (req_q.sample_time >= t_prev_q) begin
				rem_q <= req_q.sample_time - t_prev_q;
				den_q <= rd_time_q - t_prev_q;
			end else begin
				// query before the older snapshot: fraction clamps to zero
				rem_q <= '0;
				den_q <= 32'd1;
			end
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			quo_q     <= {quo_q[FRACTION_BITS-2:0], div_ge};
			if (div_ge) begin
				rem_q <= div_sh[31:0] - den_q;
			end else begin
				rem_q <= div_sh[31:0];
			end
		end
	end

	// pair positions and differences
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_x_q <= rd_x_q;
			a_y_q <= rd_y_q;
		end
		if (cmd.cap_b) begin
			diff_x_q <= $signed({rd_x_q[31], rd_x_q}) - $signed({a_x_q[31], a_x_q});
			diff_y_q <= $signed({rd_y_q[31], rd_y_q}) - $signed({a_y_q[31], a_y_q});
		end
	end

	// shared multiplier, x then y
	assign mul_a  = cmd.mul_y ? diff_y_q : diff_x_q;
	assign frac_s = $signed({1'b0, quo_q});

	always_ff @(posedge clk) begin
		if (cmd.mul_x || cmd.mul_y) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(frac_s);
		end
		// floor shift: low word of the arithmetically shifted product
		if (cmd.fin_x) begin
			res_x_q <= a_x_q + prod_q[FRACTION_BITS+31:FRACTION_BITS];
		end
		if (cmd.fin_y) begin
			res_y_q <= a_y_q + prod_q[FRACTION_BITS+31:FRACTION_BITS];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.from_history <= hist_q;
			rsp_q.out_x        <= hist_q ? res_x_q : req_q.current_x;
			rsp_q.out_y        <= hist_q ? res_y_q : req_q.current_y;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// status
	assign sts.req_valid = req_valid;
	assign sts.req_kind  = req.kind;
	assign sts.count_lt2 = (count_q < CNT_W'(2));
	assign sts.match     = (rd_time_q > req_q.sample_time);
	assign sts.walk_last = (walk_off_q == count_q);
	assign sts.div_last  = (div_cnt_q == DCNT_W'(FRACTION_BITS - 1));
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

endmodule
